@@ sv/raid2_hamming_stripe_codec_assert.svh @@
// Assertion macros used by the stripe codec emitter.
// Synthesis builds define SYNTH, which leaves every macro empty.
`ifndef RAID2_HAMMING_STRIPE_CODEC_ASSERT_SVH
`define RAID2_HAMMING_STRIPE_CODEC_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define HSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stripe codec check failed");

// Next-cycle implication, checked out of reset.
`define HSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stripe codec check failed");

`else

`define HSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/hsc_pkg.sv @@
`default_nettype none

package hsc_pkg;

	// Stripe geometry
	localparam int WORD_BITS    = 32;
	localparam int NUM_DISKS    = 7;
	localparam int NIB_BITS     = 4;
	localparam int BEAT_BITS    = 32;
	localparam int NIB_PER_BEAT = BEAT_BITS / NIB_BITS;
	localparam int NIB_SH       = $clog2(NIB_PER_BEAT);
	localparam int PACK_BITS    = WORD_BITS * NIB_BITS;
	localparam int NUM_BEATS    = PACK_BITS / BEAT_BITS;
	localparam int BEAT_IDX_W   = (NUM_BEATS > 1) ? $clog2(NUM_BEATS) : 1;
	localparam int CNT_W        = 6;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int DIRTY_W = 3;
	localparam logic       REG_MAX_DIRTY   = 1'b0;
	localparam logic [DIRTY_W-1:0] MAX_DIRTY_RESET = 3'd2;

	// Mode codes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_CHECK  = 1'b1;

	// Per-position lane result
	typedef struct packed {
		logic [NIB_BITS-1:0] nibble;  // disks 6,5,4,2 high to low
		logic [2:0]          par;     // disks 3,1,0 high to low
		logic                rep;
		logic                unrep;
	} lane_res_t;

	// Stripe handed from the lane stage to the emitter
	typedef struct packed {
		logic [PACK_BITS-1:0] nib;
		logic [WORD_BITS-1:0] par0;
		logic [WORD_BITS-1:0] par1;
		logic [WORD_BITS-1:0] par3;
		logic [WORD_BITS-1:0] rep;
		logic [WORD_BITS-1:0] unrep;
		logic [CNT_W-1:0]     pack_cnt;
	} stripe_t;

endpackage

`default_nettype wire

@@ sv/hsc_if.sv @@
`default_nettype none

// Input channel: one stripe per beat
interface hsc_stripe_if import hsc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic [WORD_BITS-1:0] word_d0;
	logic [WORD_BITS-1:0] word_d1;
	logic [WORD_BITS-1:0] word_d2;
	logic [WORD_BITS-1:0] word_d3;
	logic [WORD_BITS-1:0] word_d4;
	logic [WORD_BITS-1:0] word_d5;
	logic [WORD_BITS-1:0] word_d6;
	logic [NUM_DISKS-1:0] dirty_mask;
	logic [CNT_W-1:0]     valid_bits;

	modport source (
		output valid, mode, word_d0, word_d1, word_d2, word_d3, word_d4, word_d5, word_d6,
		output dirty_mask, valid_bits,
		input  ready
	);
	modport sink (
		input  valid, mode, word_d0, word_d1, word_d2, word_d3, word_d4, word_d5, word_d6,
		input  dirty_mask, valid_bits,
		output ready
	);
endinterface

// Output channel: one packed data word per beat
interface hsc_result_if import hsc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [BEAT_BITS-1:0] data_word;
	logic [CNT_W-1:0]     data_bits;
	logic [WORD_BITS-1:0] parity_0;
	logic [WORD_BITS-1:0] parity_1;
	logic [WORD_BITS-1:0] parity_3;
	logic [WORD_BITS-1:0] repaired_mask;
	logic [WORD_BITS-1:0] unrepairable_mask;
	logic                 last_item;

	modport source (
		output valid, data_word, data_bits, parity_0, parity_1, parity_3,
		output repaired_mask, unrepairable_mask, last_item,
		input  ready
	);
	modport sink (
		input  valid, data_word, data_bits, parity_0, parity_1, parity_3,
		input  repaired_mask, unrepairable_mask, last_item,
		output ready
	);
endinterface

`default_nettype wire

@@ sv/hsc_lane.sv @@
`default_nettype none

module hsc_lane import hsc_pkg::*; (
	input  logic                 mode,
	input  logic                 in_range,
	input  logic                 allow,
	input  logic [NUM_DISKS-1:0] dirty,
	input  logic [NUM_DISKS-1:0] code,
	output lane_res_t            res
);

	logic [2:0]           syn;
	logic [2:0]           disk;
	logic [NUM_DISKS:0]   dirty_ext;
	logic [NUM_DISKS:0]   onehot;
	logic                 err;
	logic                 fixable;
	logic [NUM_DISKS-1:0] fix;
	logic [NUM_DISKS-1:0] fixed;

	// Form the syndrome; a nonzero value names disk syn-1
	assign syn = {code[3] ^ code[4] ^ code[5] ^ code[6],
		code[1] ^ code[2] ^ code[5] ^ code[6],
		code[0] ^ code[2] ^ code[4] ^ code[6]};
	assign disk      = syn - 3'd1;
	assign dirty_ext = {1'b0, dirty};
	assign onehot    = (NUM_DISKS + 1)'(1) << disk;

	// Flip only a dirty disk, and only within the dirty-count limit
	assign err     = (mode == MODE_CHECK) && in_range && (syn != 3'd0);
	assign fixable = allow && dirty_ext[disk];
	assign fix     = (err && fixable) ? onehot[NUM_DISKS-1:0] : '0;
	assign fixed   = code ^ fix;

	always_comb begin
		res = '0;
		if (mode == MODE_CHECK) begin
			res.par   = {fixed[3], fixed[1], fixed[0]};
			res.rep   = err && fixable;
			res.unrep = err && !fixable;
			if (in_range) begin
				res.nibble = {fixed[6], fixed[5], fixed[4], fixed[2]};
			end
		end else if (in_range) begin
			res.par = {code[4] ^ code[5] ^ code[6],
				code[2] ^ code[5] ^ code[6],
				code[2] ^ code[4] ^ code[6]};
		end
	end

endmodule

`default_nettype wire

@@ sv/hsc_emit.sv @@
`default_nettype none

`include "raid2_hamming_stripe_codec_assert.svh"

module hsc_emit import hsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load_valid,
	output logic       load_ready,
	input  stripe_t    load_data,
	hsc_result_if.source result
);

	stripe_t               stripe_q;
	logic                  busy_q;
	logic [BEAT_IDX_W-1:0] idx_q;
	logic [BEAT_IDX_W-1:0] last_idx_q;
	logic [BEAT_IDX_W-1:0] last_idx;
	logic [CNT_W-1:0]      cnt_m1;
	logic [CNT_W-1:0]      rem;
	logic                  fire;
	logic                  last_fire;
	logic                  load;

	assign fire       = busy_q && result.ready;
	assign last_fire  = fire && (idx_q == last_idx_q);
	assign load_ready = !busy_q || last_fire;
	assign load       = load_valid && load_ready;

	// Final beat index of an incoming stripe
	assign cnt_m1   = load_data.pack_cnt - CNT_W'(1);
	assign last_idx = (load_data.pack_cnt == '0) ? '0 : BEAT_IDX_W'(cnt_m1 >> NIB_SH);

	// Beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else if (load) begin
			busy_q     <= 1'b1;
			idx_q      <= '0;
			last_idx_q <= last_idx;
		end else if (last_fire) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + BEAT_IDX_W'(1);
		end
	end

	// Hold the stripe for all of its beats
	always_ff @(posedge clk) begin
		if (load) begin
			stripe_q <= load_data;
		end
	end

	// Select the nibbles of the current beat
	assign rem = stripe_q.pack_cnt - (CNT_W'(idx_q) << NIB_SH);

	assign result.valid             = busy_q;
	assign result.data_word         = stripe_q.nib[idx_q * BEAT_BITS +: BEAT_BITS];
	assign result.data_bits         = (rem >= CNT_W'(NIB_PER_BEAT)) ? CNT_W'(BEAT_BITS)
		: CNT_W'(rem * NIB_BITS);
	assign result.parity_0          = stripe_q.par0;
	assign result.parity_1          = stripe_q.par1;
	assign result.parity_3          = stripe_q.par3;
	assign result.repaired_mask     = stripe_q.rep;
	assign result.unrepairable_mask = stripe_q.unrep;
	assign result.last_item         = (idx_q == last_idx_q);

	`HSC_ASSERT_IMPL(a_full_before_last, clk, arst_n, busy_q && !result.last_item, result.data_bits == CNT_W'(BEAT_BITS))
	`HSC_ASSERT_IMPL(a_masks_disjoint, clk, arst_n, busy_q, (stripe_q.rep & stripe_q.unrep) == '0)
	`HSC_ASSERT_IMPL(a_idx_bound, clk, arst_n, busy_q, idx_q <= last_idx_q)
	`HSC_ASSERT_NEXT(a_drain_idle, clk, arst_n, last_fire && !load_valid, !busy_q)

endmodule

`default_nettype wire

@@ sv/raid2_hamming_stripe_codec.sv @@
// An accepted stripe is registered in the lane stage and then in the emitter.
// Encode and empty stripes give one beat; check stripes give ceil(valid_bits/8)
// beats, at most 4, sent one per cycle while result.ready is high.
// The next stripe is taken into the lane stage while the emitter drains.
// Reset (arst_n low, asynchronous) empties both stages and sets max_dirty_disks to 2.
`default_nettype none

module raid2_hamming_stripe_codec import hsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	hsc_stripe_if.sink         stripe,
	hsc_result_if.source       result
);

	logic [DIRTY_W-1:0]   max_dirty_q;
	logic [CNT_W-1:0]     valid_sat;
	logic [DIRTY_W-1:0]   dirty_cnt;
	logic                 allow;
	logic                 accept;
	logic                 load_ready;
	logic                 valid_s1;
	stripe_t              stripe_d;
	stripe_t              stripe_s1;
	lane_res_t            lane_res [WORD_BITS];

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_DIRTY) ? PDATA_W'(max_dirty_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dirty_q <= MAX_DIRTY_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_DIRTY) begin
			max_dirty_q <= pwdata[DIRTY_W-1:0];
		end
	end

	// Clamp the valid count and decide whether repair is allowed
	assign valid_sat = (stripe.valid_bits > CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS)
		: stripe.valid_bits;

	always_comb begin
		dirty_cnt = '0;
		for (int k = 0; k < NUM_DISKS; k++) begin
			dirty_cnt = dirty_cnt + DIRTY_W'(stripe.dirty_mask[k]);
		end
	end
	assign allow = dirty_cnt <= max_dirty_q;

	// One lane per bit position
	for (genvar i = 0; i < WORD_BITS; i++) begin : g_lane
		hsc_lane u_lane (
			.mode     (stripe.mode),
			.in_range (CNT_W'(i) < valid_sat),
			.allow    (allow),
			.dirty    (stripe.dirty_mask),
			.code     ({stripe.word_d6[i], stripe.word_d5[i], stripe.word_d4[i],
				stripe.word_d3[i], stripe.word_d2[i], stripe.word_d1[i], stripe.word_d0[i]}),
			.res      (lane_res[i])
		);

		// Merge lane results into stripe words
		assign stripe_d.nib[i*NIB_BITS +: NIB_BITS] = lane_res[i].nibble;
		assign stripe_d.par0[i]  = lane_res[i].par[0];
		assign stripe_d.par1[i]  = lane_res[i].par[1];
		assign stripe_d.par3[i]  = lane_res[i].par[2];
		assign stripe_d.rep[i]   = lane_res[i].rep;
		assign stripe_d.unrep[i] = lane_res[i].unrep;
	end

	// Encode emits one beat with no data bits
	assign stripe_d.pack_cnt = (stripe.mode == MODE_CHECK) ? valid_sat : '0;

	// Lane stage register
	assign stripe.ready = !valid_s1 || load_ready;
	assign accept       = stripe.valid && stripe.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stripe_s1 <= stripe_d;
		end
	end

	// Output beats
	hsc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (load_ready),
		.load_data  (stripe_s1),
		.result     (result)
	);

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import hsc_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [PADDR_W-1:0] ADDR_MAX_DIRTY = PADDR_W'(4 * int'(REG_MAX_DIRTY));

	typedef struct packed {
		logic                                 mode;
		logic [NUM_DISKS-1:0][WORD_BITS-1:0]  word;
		logic [NUM_DISKS-1:0]                 dirty;
		logic [CNT_W-1:0]                     nvalid;
	} stripe_item_t;

	typedef struct packed {
		logic [BEAT_BITS-1:0] data_word;
		logic [CNT_W-1:0]     data_bits;
		logic [WORD_BITS-1:0] parity_0;
		logic [WORD_BITS-1:0] parity_1;
		logic [WORD_BITS-1:0] parity_3;
		logic [WORD_BITS-1:0] repaired;
		logic [WORD_BITS-1:0] unrepairable;
		logic                 last_item;
	} result_beat_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	hsc_stripe_if stripe_bus ();
	hsc_result_if result_bus ();

	raid2_hamming_stripe_codec uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.stripe  (stripe_bus),
		.result  (result_bus)
	);

	result_beat_t expected_beats[$];
	logic [DIRTY_W-1:0] cfg_max_dirty;
	int mismatches;
	int stall_cycles;
	bit calm;
	int sink_hold_req;
	int hold_left;

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Flag one field that differs from its expectation
	function automatic void check_field(input string name, input logic [WORD_BITS-1:0] exp_v,
			input logic [WORD_BITS-1:0] act_v);
		if (act_v !== exp_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t %s: expected %h, got %h", $time, name, exp_v, act_v);
		end
	endfunction

	// Compute the result beats of one accepted stripe and queue them
	function automatic void predict_stripe(input stripe_item_t it);
		logic [NUM_DISKS-1:0][WORD_BITS-1:0] d;
		logic [WORD_BITS-1:0] s1, s2, s3, vmask, rep, unrep;
		logic [2:0] syn;
		int unsigned nvalid, nbeats, pos, bits;
		bit allow;
		result_beat_t b;
		d = it.word;
		nvalid = (it.nvalid > WORD_BITS) ? WORD_BITS : it.nvalid;
		vmask = WORD_BITS'((64'd1 << nvalid) - 64'd1);
		b = '0;
		if (it.mode == MODE_ENCODE) begin
			b.parity_0 = (d[2] ^ d[4] ^ d[6]) & vmask;
			b.parity_1 = (d[2] ^ d[5] ^ d[6]) & vmask;
			b.parity_3 = (d[4] ^ d[5] ^ d[6]) & vmask;
			b.last_item = 1'b1;
			expected_beats.push_back(b);
			return;
		end
		allow = $countones(it.dirty) <= cfg_max_dirty;
		s1 = d[0] ^ d[2] ^ d[4] ^ d[6];
		s2 = d[1] ^ d[2] ^ d[5] ^ d[6];
		s3 = d[3] ^ d[4] ^ d[5] ^ d[6];
		rep = '0;
		unrep = '0;
		for (int unsigned i = 0; i < nvalid; i++) begin
			syn = {s3[i], s2[i], s1[i]};
			if (syn != 3'd0) begin
				if (allow && it.dirty[syn - 3'd1]) begin
					d[syn - 3'd1][i] = ~d[syn - 3'd1][i];
					rep[i] = 1'b1;
				end else begin
					unrep[i] = 1'b1;
				end
			end
		end
		b.parity_0 = d[0];
		b.parity_1 = d[1];
		b.parity_3 = d[3];
		b.repaired = rep;
		b.unrepairable = unrep;
		nbeats = (nvalid * NIB_BITS + BEAT_BITS - 1) / BEAT_BITS;
		if (nbeats == 0) begin
			b.last_item = 1'b1;
			expected_beats.push_back(b);
			return;
		end
		for (int unsigned r = 0; r < nbeats; r++) begin
			b.data_word = '0;
			bits = 0;
			for (int unsigned p = 0; p < NIB_PER_BEAT; p++) begin
				pos = r * NIB_PER_BEAT + p;
				if (pos >= nvalid)
					break;
				b.data_word[p*NIB_BITS +: NIB_BITS] =
					{d[6][pos], d[5][pos], d[4][pos], d[2][pos]};
				bits += NIB_BITS;
			end
			b.data_bits = CNT_W'(bits);
			b.last_item = (r == nbeats - 1);
			expected_beats.push_back(b);
		end
	endfunction

	// Valid count: mostly in range, some empty, some beyond the word
	function automatic logic [CNT_W-1:0] pick_valid();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return CNT_W'($urandom_range(WORD_BITS + 1, 63));
		return CNT_W'($urandom_range(1, WORD_BITS));
	endfunction

	// Stripe with random content everywhere
	function automatic stripe_item_t noise_stripe(input logic mode);
		stripe_item_t it;
		it.mode = mode;
		for (int k = 0; k < NUM_DISKS; k++)
			it.word[k] = $urandom();
		it.dirty = NUM_DISKS'($urandom());
		it.nvalid = pick_valid();
		return it;
	endfunction

	// Clean check stripe over the given data words
	function automatic stripe_item_t make_codeword(input logic [WORD_BITS-1:0] d2, d4, d5, d6);
		stripe_item_t it;
		it.mode = MODE_CHECK;
		it.word[2] = d2;
		it.word[4] = d4;
		it.word[5] = d5;
		it.word[6] = d6;
		it.word[0] = d2 ^ d4 ^ d6;
		it.word[1] = d2 ^ d5 ^ d6;
		it.word[3] = d4 ^ d5 ^ d6;
		it.dirty = '0;
		it.nvalid = CNT_W'(WORD_BITS);
		return it;
	endfunction

	// Flip sparse bits on up to two disks and mark them dirty, mostly
	function automatic stripe_item_t corrupt(input stripe_item_t it);
		int unsigned kind, k, j;
		kind = $urandom_range(0, 9);
		it.dirty = NUM_DISKS'($urandom() & $urandom() & $urandom());
		if (kind < 2)
			return it;
		k = $urandom_range(0, NUM_DISKS - 1);
		it.word[k] ^= $urandom() & $urandom();
		if ($urandom_range(0, 9) != 0)
			it.dirty[k] = 1'b1;
		if (kind >= 7) begin
			j = $urandom_range(0, NUM_DISKS - 1);
			it.word[j] ^= $urandom() & $urandom() & $urandom();
			it.dirty[j] = 1'b1;
		end
		return it;
	endfunction

	// Mostly corrupted codewords, some encodes and some noise
	function automatic stripe_item_t next_random_stripe();
		stripe_item_t it;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return noise_stripe(MODE_ENCODE);
		if (r >= 85)
			return noise_stripe(MODE_CHECK);
		it = corrupt(make_codeword($urandom(), $urandom(), $urandom(), $urandom()));
		it.nvalid = pick_valid();
		return it;
	endfunction

	// Offer one stripe, after a random gap, and hold it until accepted
	task automatic send_stripe(input stripe_item_t it);
		while (!calm && $urandom_range(0, 99) < 30) begin
			stripe_bus.valid <= 1'b0;
			@(posedge clk);
		end
		stripe_bus.valid      <= 1'b1;
		stripe_bus.mode       <= it.mode;
		stripe_bus.word_d0    <= it.word[0];
		stripe_bus.word_d1    <= it.word[1];
		stripe_bus.word_d2    <= it.word[2];
		stripe_bus.word_d3    <= it.word[3];
		stripe_bus.word_d4    <= it.word[4];
		stripe_bus.word_d5    <= it.word[5];
		stripe_bus.word_d6    <= it.word[6];
		stripe_bus.dirty_mask <= it.dirty;
		stripe_bus.valid_bits <= it.nvalid;
		do @(posedge clk); while (!stripe_bus.ready);
		predict_stripe(it);
	endtask

	// Drop valid and wait until every queued beat has come out
	task automatic wait_drain();
		stripe_bus.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB transfer: setup, then access until pready
	task automatic apb_access(input logic write, input logic [PDATA_W-1:0] wdata,
			output logic [PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= ADDR_MAX_DIRTY;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write the dirty-disk limit and read it back
	task automatic set_max_dirty(input logic [DIRTY_W-1:0] value);
		logic [PDATA_W-1:0] rd;
		apb_access(1'b1, PDATA_W'(value), rd);
		cfg_max_dirty = value;
		apb_access(1'b0, '0, rd);
		check_field("max_dirty_disks readback", PDATA_W'(cfg_max_dirty), rd);
	endtask

	task automatic test_encode_corners();
		stripe_item_t it;
		it = '0;
		it.mode = MODE_ENCODE;
		it.nvalid = CNT_W'(WORD_BITS);
		send_stripe(it);
		it.word = '1;
		it.dirty = '1;
		send_stripe(it);
		it.nvalid = '0;
		send_stripe(it);
		it = noise_stripe(MODE_ENCODE);
		it.nvalid = CNT_W'(WORD_BITS + 1);
		send_stripe(it);
		it = noise_stripe(MODE_ENCODE);
		it.nvalid = '1;
		send_stripe(it);
		it = noise_stripe(MODE_ENCODE);
		it.nvalid = CNT_W'(1);
		send_stripe(it);
		it = noise_stripe(MODE_ENCODE);
		it.nvalid = CNT_W'(WORD_BITS - 1);
		it.dirty = '1;
		send_stripe(it);
		wait_drain();
	endtask

	task automatic test_check_corners();
		stripe_item_t it;
		logic [PDATA_W-1:0] rd;
		int lens[5];
		lens = '{1, 8, 9, 24, 25};
		// register comes out of reset at its default
		apb_access(1'b0, '0, rd);
		check_field("max_dirty_disks after reset", PDATA_W'(MAX_DIRTY_RESET), rd);
		cfg_max_dirty = MAX_DIRTY_RESET;
		send_stripe(make_codeword('1, '1, '1, '1));
		it = noise_stripe(MODE_CHECK);
		it.nvalid = '0;
		send_stripe(it);
		it = noise_stripe(MODE_CHECK);
		it.nvalid = '1;
		it.dirty = '1;
		send_stripe(it);
		// one bad disk, marked dirty: repair it
		for (int k = 0; k < NUM_DISKS; k++) begin
			it = make_codeword($urandom(), $urandom(), $urandom(), $urandom());
			it.word[k] ^= $urandom() | 32'h8000_0001;
			it.dirty = NUM_DISKS'(1) << k;
			send_stripe(it);
		end
		// bad disk not the dirty one
		it = make_codeword($urandom(), $urandom(), $urandom(), $urandom());
		it.word[2] ^= $urandom() | 1;
		it.dirty = NUM_DISKS'(1) << 4;
		send_stripe(it);
		// more dirty disks than the limit allows
		it = make_codeword($urandom(), $urandom(), $urandom(), $urandom());
		it.word[5] ^= $urandom() | 1;
		it.dirty = 7'b0100110;
		send_stripe(it);
		// short stripes around beat boundaries, errors above the count pass through
		foreach (lens[i]) begin
			it = noise_stripe(MODE_CHECK);
			it.nvalid = CNT_W'(lens[i]);
			send_stripe(it);
		end
		wait_drain();
	endtask

	task automatic test_repair_limit();
		logic [DIRTY_W-1:0] limits[4];
		limits = '{3'd0, 3'd7, 3'd1, 3'd4};
		foreach (limits[i]) begin
			set_max_dirty(limits[i]);
			repeat (15) send_stripe(next_random_stripe());
			wait_drain();
		end
	endtask

	task automatic test_random_traffic();
		repeat (5) begin
			set_max_dirty(DIRTY_W'($urandom_range(0, 7)));
			repeat (50) send_stripe(next_random_stripe());
			wait_drain();
		end
	endtask

	task automatic test_streaming();
		calm = 1'b1;
		repeat (70) send_stripe(next_random_stripe());
		wait_drain();
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		// stall the receiver while stripes keep coming
		sink_hold_req = HOLD_CYCLES;
		repeat (25) send_stripe(next_random_stripe());
		wait_drain();
	endtask

	// Receiver: random stalls, a calm stretch, and a long hold-off on request
	initial begin
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_req != 0) begin
				hold_left = sink_hold_req;
				sink_hold_req = 0;
			end
			if (hold_left != 0) begin
				result_bus.ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				result_bus.ready <= 1'b1;
			end else begin
				result_bus.ready <= ($urandom_range(0, 99) >= 30);
			end
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		result_beat_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected result beat, data_word %h", $time,
						result_bus.data_word);
			end else begin
				want = expected_beats.pop_front();
				check_field("data_word", want.data_word, result_bus.data_word);
				check_field("data_bits", WORD_BITS'(want.data_bits),
					WORD_BITS'(result_bus.data_bits));
				check_field("parity_0", want.parity_0, result_bus.parity_0);
				check_field("parity_1", want.parity_1, result_bus.parity_1);
				check_field("parity_3", want.parity_3, result_bus.parity_3);
				check_field("repaired_mask", want.repaired, result_bus.repaired_mask);
				check_field("unrepairable_mask", want.unrepairable,
					result_bus.unrepairable_mask);
				check_field("last_item", WORD_BITS'(want.last_item),
					WORD_BITS'(result_bus.last_item));
			end
		end
	end

	// Watchdog: end the run when work is pending and nothing moves
	always @(posedge clk) begin
		if (arst_n && (stripe_bus.valid || expected_beats.size() != 0)
				&& !(stripe_bus.valid && stripe_bus.ready)
				&& !(result_bus.valid && result_bus.ready)) begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end else begin
			stall_cycles = 0;
		end
	end

	initial begin
		mismatches = 0;
		stall_cycles = 0;
		calm = 1'b0;
		sink_hold_req = 0;
		hold_left = 0;
		cfg_max_dirty = MAX_DIRTY_RESET;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stripe_bus.valid = 1'b0;
		stripe_bus.mode = MODE_ENCODE;
		stripe_bus.word_d0 = '0;
		stripe_bus.word_d1 = '0;
		stripe_bus.word_d2 = '0;
		stripe_bus.word_d3 = '0;
		stripe_bus.word_d4 = '0;
		stripe_bus.word_d5 = '0;
		stripe_bus.word_d6 = '0;
		stripe_bus.dirty_mask = '0;
		stripe_bus.valid_bits = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encode_corners();
		test_check_corners();
		test_repair_limit();
		test_random_traffic();
		test_streaming();
		test_backpressure();

		// let any stray beat show up before the verdict
		repeat (10) @(posedge clk);
		mismatches += expected_beats.size();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

@@ raid2_hamming_stripe_codec.f @@
+incdir+sv
sv/hsc_pkg.sv
sv/hsc_if.sv
sv/hsc_lane.sv
sv/hsc_emit.sv
sv/raid2_hamming_stripe_codec.sv
tb/tb.sv
